// ----- src/sipq_pkg.sv -----
// ----------------------------------------------------------------------------
// sipq_pkg: shared types and constants
// Status codes, operation codes and default depth for the sorted queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sipq_pkg;

  // default number of entries
  localparam int unsigned DEPTH_DEF = 16;

  // field widths
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // operation codes carried on mode
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // result status
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  // shift commands broadcast to every cell
  typedef struct packed {
    logic ins;  // insert shift towards the tail
    logic rem;  // remove shift towards the head
  } shift_t;

endpackage

`default_nettype wire

// ----- src/sipq_cell.sv -----
// ----------------------------------------------------------------------------
// sipq_cell: one slot of the sorted row
// Holds one entry, flags whether the new value goes in front of it and
// takes its next value from itself, the new value or a neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module sipq_cell (
  input  wire logic                              clk_i,
  input  wire sipq_pkg::shift_t                  shift_i,
  input  wire logic                              occupied_i,
  input  wire logic signed [sipq_pkg::VALUE_W-1:0] value_i,
  input  wire logic                              prev_greater_i,
  input  wire logic signed [sipq_pkg::VALUE_W-1:0] prev_entry_i,
  input  wire logic signed [sipq_pkg::VALUE_W-1:0] next_entry_i,
  output logic                                   greater_o,
  output logic signed [sipq_pkg::VALUE_W-1:0]    entry_o
);
  import sipq_pkg::*;

  logic signed [VALUE_W-1:0] entry_q, entry_d;

  // a free slot counts as greater so the first free slot takes the value
  assign greater_o = !occupied_i || (value_i < entry_q);

  // next entry selection
  always_comb begin
    entry_d = entry_q;
    if (shift_i.ins) begin
      if (prev_greater_i) begin
        entry_d = prev_entry_i;
      end else if (greater_o) begin
        entry_d = value_i;
      end
    end else if (shift_i.rem) begin
      entry_d = next_entry_i;
    end
  end

  // entry register, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ----- src/sorted_insert_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue: bounded ascending priority queue
// Row of compare-and-shift cells; insert places a value before the first
// strictly greater entry, remove pops the head.
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after its beat is accepted
// throughput: one item per cycle unless the held result is stalled, set by the
//   compare and shift across the cell row and the one-deep output register
// reset: clears the entry count and the output valid; entry contents are
//   left as they are and only slots below the count are ever read
`default_nettype none

module sorted_insert_priority_queue #(
  parameter int unsigned DEPTH = sipq_pkg::DEPTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 mode_i,
  input  wire logic signed [sipq_pkg::VALUE_W-1:0]  value_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [sipq_pkg::VALUE_W-1:0]       removed_value_o,
  output logic [sipq_pkg::STATUS_W-1:0]             status_o
);
  import sipq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]          count_q, count_d;
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] removed_q, removed_d;
  status_e                   status_q, status_d;

  logic                      accept;
  logic                      full, empty;
  shift_t                    shift;

  logic                      greater [DEPTH];
  logic signed [VALUE_W-1:0] entry   [DEPTH];

  // handshake: take a beat unless the held result is stalled
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  // operation decode
  always_comb begin
    shift.ins = accept && (mode_i == MODE_INSERT) && !full;
    shift.rem = accept && (mode_i == MODE_REMOVE) && !empty;
    count_d   = count_q;
    removed_d = '0;
    status_d  = ST_DONE;
    if (shift.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (shift.rem) begin
      count_d   = count_q - CNT_W'(1);
      removed_d = entry[0];
    end else if (mode_i == MODE_INSERT) begin
      status_d = ST_OVERFLOW;
    end else begin
      status_d = ST_EMPTY;
    end
  end

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      prev_greater;
    logic signed [VALUE_W-1:0] prev_entry, next_entry;

    if (i == 0) begin : g_head
      assign prev_greater = 1'b0;
      assign prev_entry   = value_i;
    end else begin : g_body
      assign prev_greater = greater[i-1];
      assign prev_entry   = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_entry = entry[i];
    end else begin : g_inner
      assign next_entry = entry[i+1];
    end

    sipq_cell u_cell (
      .clk_i          (clk_i),
      .shift_i        (shift),
      .occupied_i     (CNT_W'(i) < count_q),
      .value_i        (value_i),
      .prev_greater_i (prev_greater),
      .prev_entry_i   (prev_entry),
      .next_entry_i   (next_entry),
      .greater_o      (greater[i]),
      .entry_o        (entry[i])
    );
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q <= removed_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign status_o        = status_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift.ins |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_rem_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift.rem |=> (removed_q == $past(entry[0])) && (status_q == ST_DONE))
    else $error("remove did not return the head entry");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mode_i == MODE_REMOVE) && empty)
      |=> (status_q == ST_EMPTY) && (removed_q == '0) && (count_q == '0))
    else $error("remove from empty queue mishandled");

endmodule

`default_nettype wire
